[rtl/core/ccrd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrd_pkg
// types and constants of the canonical cbor record decoder
// ----------------------------------------------------------------------------
package ccrd_pkg;

  // length of the device id and nonce byte strings
  localparam int unsigned ID_BYTES = 16;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // apb register map
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // cbor major types
  localparam logic [2:0] MAJOR_UINT = 3'd0;
  localparam logic [2:0] MAJOR_BSTR = 3'd2;
  localparam logic [2:0] MAJOR_MAP  = 3'd5;

  // additional info codes
  localparam logic [4:0] AI_INLINE_LIMIT = 5'd24;
  localparam logic [4:0] AI_ARG_U64      = 5'd27;

  localparam logic [7:0] VERSION_RESET = 8'd2;
  localparam logic [63:0] MAP_ENTRIES  = 64'd6;

  typedef enum logic [3:0] {
    STEP_MAP        = 4'd0,
    STEP_KEY0       = 4'd1,
    STEP_VERSION    = 4'd2,
    STEP_KEY1       = 4'd3,
    STEP_ID_LEN     = 4'd4,
    STEP_ID_DATA    = 4'd5,
    STEP_KEY2       = 4'd6,
    STEP_NONCE_LEN  = 4'd7,
    STEP_NONCE_DATA = 4'd8,
    STEP_KEY3       = 4'd9,
    STEP_CAP        = 4'd10,
    STEP_KEY4       = 4'd11,
    STEP_LIFE       = 4'd12,
    STEP_KEY5       = 4'd13,
    STEP_SEQ        = 4'd14,
    STEP_DONE       = 4'd15
  } schema_step_e;

  typedef enum logic [2:0] {
    KIND_VERSION    = 3'd0,
    KIND_DEVICE_ID  = 3'd1,
    KIND_NONCE      = 3'd2,
    KIND_CAPABILITY = 3'd3,
    KIND_LIFETIME   = 3'd4,
    KIND_SEQUENCE   = 3'd5,
    KIND_STATUS     = 3'd6
  } field_kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_NONMIN    = 3'd2,
    ST_TYPE      = 3'd3,
    ST_LENGTH    = 3'd4,
    ST_VERSION   = 3'd5,
    ST_TRAILING  = 3'd6,
    ST_OVERFLOW  = 3'd7
  } status_e;

  typedef enum logic [0:0] {
    REG_REQUIRED_VERSION = 1'b0
  } reg_index_e;

  typedef struct packed {
    field_kind_e kind;
    logic [3:0]  idx;
    logic [63:0] value;
    status_e     status;
    logic        record_end;
  } result_t;

endpackage

[rtl/core/canonical_cbor_record_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_cbor_record_decoder
// byte-serial checker and field extractor for a fixed deterministic cbor record
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// input     in         in_valid_i / in_ready_o   data_byte_i, last_byte_i
// result    out        out_valid_o / out_ready_i field_kind_o, byte_index_o,
//                                                field_value_o, status_o,
//                                                record_end_o
// config    in         psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// one byte is accepted per cycle while in_ready_o is high; its parse update
// is done in the cycle of the transfer and its results land in a four-entry
// result queue; the queue sends one result per cycle while out_ready_i is
// high, so a byte that yields a field and the closing status queues two results
// in_ready_o drops while the queue cannot take two more results
// asynchronous active-low reset clears the parse state and the queue and
// sets required_version to 2; no clearing pass follows reset
// the queue read side decides the output rate; stalls on out_ready_i fill
// the queue and, once it cannot take two more results, hold in_ready_o low
// ----------------------------------------------------------------------------
module canonical_cbor_record_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // byte input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            last_byte_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      field_kind_o,
  output logic [3:0]                      byte_index_o,
  output logic [63:0]                     field_value_o,
  output logic [2:0]                      status_o,
  output logic                            record_end_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ccrd_pkg::APB_AW-1:0]     paddr,
  input  logic [ccrd_pkg::APB_DW-1:0]     pwdata,
  output logic [ccrd_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);

  localparam logic [4:0] IdBytesC = 5'(ccrd_pkg::ID_BYTES);

  // configuration register
  logic [7:0] req_ver_q;

  // parse state
  ccrd_pkg::schema_step_e step_q, step_d;
  logic [3:0]  left_q, left_d;
  logic [3:0]  width_q, width_d;
  logic [63:0] acc_q, acc_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        disc_q, disc_d;

  // result queue
  ccrd_pkg::result_t                  fifo_q [ccrd_pkg::FIFO_DEPTH];
  logic [ccrd_pkg::FIFO_AW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [ccrd_pkg::FIFO_CW-1:0]       fcnt_q, fcnt_d;
  ccrd_pkg::result_t                  out_res;

  logic        in_fire, out_fire, cfg_wr;
  logic        fld_valid, stat_valid, val_valid;
  ccrd_pkg::result_t fld_res, stat_res, first_res;
  ccrd_pkg::status_e err;
  logic [63:0] val;
  logic [63:0] acc_shift;
  logic [3:0]  left_dec;
  logic [4:0]  info;
  logic [2:0]  major_exp;
  logic [1:0]  push_n;
  logic        nonmin;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;

  // ---------------------------------------------------------------------------
  // apb register port, register decoded on the word address bit
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite &
                  (paddr[2] == ccrd_pkg::REG_REQUIRED_VERSION);
  assign prdata = (paddr[2] == ccrd_pkg::REG_REQUIRED_VERSION) ?
                  {{(ccrd_pkg::APB_DW - 8){1'b0}}, req_ver_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ver_q <= ccrd_pkg::VERSION_RESET;
    end else if (cfg_wr) begin
      req_ver_q <= pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------------------
  // byte parser
  // ---------------------------------------------------------------------------
  assign acc_shift = {acc_q[55:0], data_byte_i};
  assign left_dec  = left_q - 4'd1;
  assign info      = data_byte_i[4:0];

  // major type expected for a head at the current step
  always_comb begin
    unique case (step_q)
      ccrd_pkg::STEP_MAP:                                major_exp = ccrd_pkg::MAJOR_MAP;
      ccrd_pkg::STEP_ID_LEN, ccrd_pkg::STEP_NONCE_LEN:   major_exp = ccrd_pkg::MAJOR_BSTR;
      default:                                           major_exp = ccrd_pkg::MAJOR_UINT;
    endcase
  end

  // shortest-form rule on a completed argument carried in extra bytes
  assign nonmin = ((width_q == 4'd1) && (acc_shift < 64'd24)) ||
                  ((width_q == 4'd2) && (acc_shift <= 64'hff)) ||
                  ((width_q == 4'd4) && (acc_shift <= 64'hffff)) ||
                  ((width_q == 4'd8) && (acc_shift <= 64'hffff_ffff));

  always_comb begin
    step_d     = step_q;
    left_d     = left_q;
    width_d    = width_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    disc_d     = disc_q;
    fld_valid  = 1'b0;
    stat_valid = 1'b0;
    val_valid  = 1'b0;
    val        = '0;
    err        = ccrd_pkg::ST_OK;
    fld_res    = '{kind: ccrd_pkg::KIND_VERSION, idx: 4'd0, value: 64'd0,
                   status: ccrd_pkg::ST_OK, record_end: 1'b0};
    stat_res   = '{kind: ccrd_pkg::KIND_STATUS, idx: 4'd0, value: 64'd0,
                   status: ccrd_pkg::ST_OK, record_end: 1'b1};

    if (in_fire && !disc_q) begin
      if (step_q == ccrd_pkg::STEP_DONE) begin
        err = ccrd_pkg::ST_TRAILING;
      end else if (step_q == ccrd_pkg::STEP_ID_DATA ||
                   step_q == ccrd_pkg::STEP_NONCE_DATA) begin
        // string payload byte
        fld_valid     = 1'b1;
        fld_res.kind  = (step_q == ccrd_pkg::STEP_ID_DATA) ?
                        ccrd_pkg::KIND_DEVICE_ID : ccrd_pkg::KIND_NONCE;
        fld_res.idx   = cnt_q[3:0];
        fld_res.value = 64'(data_byte_i);
        cnt_d         = cnt_q + 5'd1;
        if (cnt_d >= IdBytesC) begin
          step_d = ccrd_pkg::schema_step_e'(step_q + 4'd1);
        end
      end else if (left_q == 4'd0) begin
        // head byte
        if (data_byte_i[7:5] != major_exp) begin
          err = ccrd_pkg::ST_TYPE;
        end else if (info < ccrd_pkg::AI_INLINE_LIMIT) begin
          val_valid = 1'b1;
          val       = 64'(info);
        end else if (info <= ccrd_pkg::AI_ARG_U64) begin
          width_d = 4'd1 << info[1:0];
          left_d  = 4'd1 << info[1:0];
          acc_d   = '0;
        end else begin
          err = ccrd_pkg::ST_TRUNCATED;
        end
      end else begin
        // argument byte, big endian
        acc_d  = acc_shift;
        left_d = left_dec;
        if (left_dec == 4'd0) begin
          if (nonmin) begin
            err = ccrd_pkg::ST_NONMIN;
          end else begin
            val_valid = 1'b1;
            val       = acc_shift;
          end
        end
      end

      // a complete argument checked against the layout
      if (val_valid) begin
        unique case (step_q)
          ccrd_pkg::STEP_MAP: begin
            if (val != ccrd_pkg::MAP_ENTRIES) err = ccrd_pkg::ST_TYPE;
          end
          ccrd_pkg::STEP_KEY0: if (val != 64'd0) err = ccrd_pkg::ST_TYPE;
          ccrd_pkg::STEP_KEY1: if (val != 64'd1) err = ccrd_pkg::ST_TYPE;
          ccrd_pkg::STEP_KEY2: if (val != 64'd2) err = ccrd_pkg::ST_TYPE;
          ccrd_pkg::STEP_KEY3: if (val != 64'd3) err = ccrd_pkg::ST_TYPE;
          ccrd_pkg::STEP_KEY4: if (val != 64'd4) err = ccrd_pkg::ST_TYPE;
          ccrd_pkg::STEP_KEY5: if (val != 64'd5) err = ccrd_pkg::ST_TYPE;
          ccrd_pkg::STEP_VERSION: begin
            if (val != 64'(req_ver_q)) begin
              err = ccrd_pkg::ST_VERSION;
            end else begin
              fld_valid     = 1'b1;
              fld_res.kind  = ccrd_pkg::KIND_VERSION;
              fld_res.value = val;
            end
          end
          ccrd_pkg::STEP_ID_LEN, ccrd_pkg::STEP_NONCE_LEN: begin
            if (val != 64'(ccrd_pkg::ID_BYTES)) begin
              err = ccrd_pkg::ST_LENGTH;
            end else begin
              cnt_d = '0;
            end
          end
          ccrd_pkg::STEP_CAP, ccrd_pkg::STEP_LIFE: begin
            if (val > 64'hffff_ffff) begin
              err = ccrd_pkg::ST_OVERFLOW;
            end else begin
              fld_valid     = 1'b1;
              fld_res.kind  = (step_q == ccrd_pkg::STEP_CAP) ?
                              ccrd_pkg::KIND_CAPABILITY : ccrd_pkg::KIND_LIFETIME;
              fld_res.value = val;
            end
          end
          ccrd_pkg::STEP_SEQ: begin
            fld_valid     = 1'b1;
            fld_res.kind  = ccrd_pkg::KIND_SEQUENCE;
            fld_res.value = val;
          end
          default: err = ccrd_pkg::ST_TYPE;
        endcase
        if (err == ccrd_pkg::ST_OK) begin
          step_d = ccrd_pkg::schema_step_e'(step_q + 4'd1);
        end
      end

      // closing status: on error, or on the last byte of the record
      if (err != ccrd_pkg::ST_OK) begin
        stat_valid      = 1'b1;
        stat_res.status = err;
        disc_d          = 1'b1;
      end else if (last_byte_i) begin
        stat_valid      = 1'b1;
        stat_res.status = (step_d == ccrd_pkg::STEP_DONE) ?
                          ccrd_pkg::ST_OK : ccrd_pkg::ST_TRUNCATED;
      end
    end

    // last byte always returns the parser to its reset state
    if (in_fire && last_byte_i) begin
      step_d  = ccrd_pkg::STEP_MAP;
      left_d  = '0;
      width_d = '0;
      acc_d   = '0;
      cnt_d   = '0;
      disc_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ccrd_pkg::STEP_MAP;
      left_q  <= '0;
      width_q <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      disc_q  <= 1'b0;
    end else begin
      step_q  <= step_d;
      left_q  <= left_d;
      width_q <= width_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      disc_q  <= disc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result queue: field result first, then the status
  // ---------------------------------------------------------------------------
  assign push_n    = {1'b0, fld_valid} + {1'b0, stat_valid};
  assign first_res = fld_valid ? fld_res : stat_res;
  assign fcnt_d    = fcnt_q + ccrd_pkg::FIFO_CW'(push_n)
                   - ccrd_pkg::FIFO_CW'(out_fire);

  assign in_ready_o  = fcnt_q <= ccrd_pkg::FIFO_CW'(ccrd_pkg::FIFO_DEPTH - 2);
  assign out_valid_o = fcnt_q != '0;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= first_res;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + ccrd_pkg::FIFO_AW'(1)] <= stat_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fcnt_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + ccrd_pkg::FIFO_AW'(push_n);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + ccrd_pkg::FIFO_AW'(1);
      end
      fcnt_q <= fcnt_d;
    end
  end

  assign out_res       = fifo_q[rd_ptr_q];
  assign field_kind_o  = out_res.kind;
  assign byte_index_o  = out_res.idx;
  assign field_value_o = out_res.value;
  assign status_o      = out_res.status;
  assign record_end_o  = out_res.record_end;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  // queue never overfills
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= ccrd_pkg::FIFO_CW'(ccrd_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // a last byte leaves the parser in its reset state
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_byte_i) |=> (step_q == ccrd_pkg::STEP_MAP && !disc_q &&
                                  left_q == 4'd0 && cnt_q == 5'd0))
    else $error("parse state not cleared after last byte");

  // bytes after an error yield nothing
  a_discard_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && disc_q) |-> (push_n == 2'd0))
    else $error("result produced while discarding");

  // record_end marks exactly the status results
  a_end_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (record_end_o == (field_kind_o == ccrd_pkg::KIND_STATUS)))
    else $error("record_end and status kind disagree");
`endif

endmodule

[test/ccrd_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrd_stream_checker
// watches the byte, result and register ports of the cbor record decoder,
// decodes every accepted byte on its own and compares each result transfer
// with the oldest result still due
// ----------------------------------------------------------------------------
module ccrd_stream_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [7:0]                  data_byte_i,
  input  logic                        last_byte_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [2:0]                  field_kind_i,
  input  logic [3:0]                  byte_index_i,
  input  logic [63:0]                 field_value_i,
  input  logic [2:0]                  status_i,
  input  logic                        record_end_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [ccrd_pkg::APB_AW-1:0] paddr_i,
  input  logic [ccrd_pkg::APB_DW-1:0] pwdata_i,
  output int unsigned                 mismatches_o,
  output int unsigned                 compared_o,
  output int unsigned                 pending_o
);

  import ccrd_pkg::*;

  // local copy of the register and the parse state
  logic [7:0]   want_version;
  schema_step_e rec_step;
  logic [3:0]   arg_left;
  logic [3:0]   arg_width;
  logic [63:0]  arg_acc;
  logic [4:0]   str_count;
  logic         skip_rest;

  result_t      due_results [$];
  int unsigned  mismatches;
  int unsigned  compared;

  task automatic add_due(input field_kind_e kind, input logic [3:0] idx,
                         input logic [63:0] value, input status_e st,
                         input logic rec_end);
    result_t r;
    r.kind       = kind;
    r.idx        = idx;
    r.value      = value;
    r.status     = st;
    r.record_end = rec_end;
    due_results.push_back(r);
  endtask

  task automatic restart_parse();
    rec_step  = STEP_MAP;
    arg_left  = '0;
    arg_width = '0;
    arg_acc   = '0;
    str_count = '0;
    skip_rest = 1'b0;
  endtask

  function automatic logic [2:0] head_major(input schema_step_e s);
    case (s)
      STEP_MAP:                      return MAJOR_MAP;
      STEP_ID_LEN, STEP_NONCE_LEN:   return MAJOR_BSTR;
      default:                       return MAJOR_UINT;
    endcase
  endfunction

  // a complete head argument at the current layout position
  task automatic finish_argument(input logic [63:0] v, output status_e st);
    logic [63:0] key;
    st = ST_OK;
    case (rec_step)
      STEP_MAP: begin
        if (v != MAP_ENTRIES) st = ST_TYPE;
      end
      STEP_KEY0, STEP_KEY1, STEP_KEY2, STEP_KEY3, STEP_KEY4, STEP_KEY5: begin
        key = (rec_step == STEP_KEY0) ? 64'd0 : (rec_step == STEP_KEY1) ? 64'd1 :
              (rec_step == STEP_KEY2) ? 64'd2 : (rec_step == STEP_KEY3) ? 64'd3 :
              (rec_step == STEP_KEY4) ? 64'd4 : 64'd5;
        if (v != key) st = ST_TYPE;
      end
      STEP_VERSION: begin
        if (v != {56'd0, want_version}) st = ST_VERSION;
        else add_due(KIND_VERSION, 4'd0, v, ST_OK, 1'b0);
      end
      STEP_ID_LEN, STEP_NONCE_LEN: begin
        if (v != 64'(ID_BYTES)) st = ST_LENGTH;
        else str_count = '0;
      end
      STEP_CAP, STEP_LIFE: begin
        if (v > 64'hffff_ffff) st = ST_OVERFLOW;
        else add_due((rec_step == STEP_CAP) ? KIND_CAPABILITY : KIND_LIFETIME,
                     4'd0, v, ST_OK, 1'b0);
      end
      STEP_SEQ: begin
        add_due(KIND_SEQUENCE, 4'd0, v, ST_OK, 1'b0);
      end
      default: begin
        st = ST_TYPE;
      end
    endcase
    if (st == ST_OK) rec_step = schema_step_e'(rec_step + 4'd1);
  endtask

  task automatic parse_byte(input logic [7:0] b, output status_e st);
    logic [4:0]  info;
    logic [63:0] v;
    st   = ST_OK;
    info = b[4:0];
    if (rec_step == STEP_DONE) begin
      st = ST_TRAILING;
    end else if (rec_step == STEP_ID_DATA || rec_step == STEP_NONCE_DATA) begin
      add_due((rec_step == STEP_ID_DATA) ? KIND_DEVICE_ID : KIND_NONCE,
              str_count[3:0], {56'd0, b}, ST_OK, 1'b0);
      str_count = str_count + 5'd1;
      if (str_count >= ID_BYTES) rec_step = schema_step_e'(rec_step + 4'd1);
    end else if (arg_left == 4'd0) begin
      if (b[7:5] != head_major(rec_step)) begin
        st = ST_TYPE;
      end else if (info < AI_INLINE_LIMIT) begin
        finish_argument({59'd0, info}, st);
      end else if (info <= AI_ARG_U64) begin
        arg_width = 4'd1 << (info - AI_INLINE_LIMIT);
        arg_left  = arg_width;
        arg_acc   = '0;
      end else begin
        // indefinite length or reserved additional info
        st = ST_TRUNCATED;
      end
    end else begin
      arg_acc  = {arg_acc[55:0], b};
      arg_left = arg_left - 4'd1;
      if (arg_left == 4'd0) begin
        v = arg_acc;
        if ((arg_width == 4'd1 && v < 64'(AI_INLINE_LIMIT)) ||
            (arg_width == 4'd2 && v <= 64'hff) ||
            (arg_width == 4'd4 && v <= 64'hffff) ||
            (arg_width == 4'd8 && v <= 64'hffff_ffff))
          st = ST_NONMIN;
        else
          finish_argument(v, st);
      end
    end
  endtask

  // expected results of one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic last);
    status_e st;
    if (skip_rest) begin
      if (last) restart_parse();
    end else begin
      parse_byte(b, st);
      if (st != ST_OK) begin
        add_due(KIND_STATUS, 4'd0, 64'd0, st, 1'b1);
        if (last) restart_parse();
        else skip_rest = 1'b1;
      end else if (last) begin
        add_due(KIND_STATUS, 4'd0, 64'd0,
                (rec_step == STEP_DONE) ? ST_OK : ST_TRUNCATED, 1'b1);
        restart_parse();
      end
    end
  endtask

  task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      want_version = VERSION_RESET;
      restart_parse();
      due_results.delete();
      mismatches   = 0;
      compared     = 0;
      mismatches_o <= 0;
      compared_o   <= 0;
      pending_o    <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[ccrd_pkg::APB_AW-1:2] == REG_REQUIRED_VERSION)
        want_version = pwdata_i[7:0];
      if (in_valid_i && in_ready_i) decode_byte(data_byte_i, last_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          flag("unexpected result, kind/status", 64'd0, {58'd0, field_kind_i, status_i});
        end else begin
          want = due_results.pop_front();
          compared++;
          if (field_kind_i != want.kind)
            flag("field_kind", 64'(want.kind), 64'(field_kind_i));
          if (byte_index_i != want.idx)
            flag("byte_index", 64'(want.idx), 64'(byte_index_i));
          if (field_value_i != want.value)
            flag("field_value", want.value, field_value_i);
          if (status_i != want.status)
            flag("status", 64'(want.status), 64'(status_i));
          if (record_end_i != want.record_end)
            flag("record_end", 64'(want.record_end), 64'(record_end_i));
        end
      end
      mismatches_o <= mismatches;
      compared_o   <= compared;
      pending_o    <= due_results.size();
    end
  end

endmodule

[test/canonical_cbor_record_decoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_cbor_record_decoder_test
// feeds short hand-made byte runs, then random records (clean, cut short,
// corrupted heads, bad arguments, wide values, trailing bytes, noise) under
// several required versions, with random gaps on the byte side and random
// stalls on the result side; a checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module canonical_cbor_record_decoder_test;

  import ccrd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PHASE_BYTES  = 250;
  // no register lives at index 1
  localparam logic [APB_AW-1:0] SPARE_ADDR = 3'd4;
  localparam logic [APB_AW-1:0] VERSION_ADDR = {REG_REQUIRED_VERSION, 2'b00};

  // how a random record is damaged, if at all
  typedef enum int unsigned {
    REC_CLEAN,
    REC_CUT_SHORT,
    REC_NONMINIMAL,
    REC_BAD_MAJOR,
    REC_RESERVED_INFO,
    REC_BAD_ARGUMENT,
    REC_WIDE_VALUE,
    REC_TRAILING,
    REC_NOISE
  } rec_flaw_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [7:0]          data_byte_i = 8'd0;
  logic                last_byte_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [2:0]          field_kind_o;
  logic [3:0]          byte_index_o;
  logic [63:0]         field_value_o;
  logic [2:0]          status_o;
  logic                record_end_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [APB_AW-1:0]   paddr       = '0;
  logic [APB_DW-1:0]   pwdata      = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int unsigned         mismatches;
  int unsigned         compared;
  int unsigned         pending;

  // stimulus bookkeeping
  logic [7:0]          cfg_version = VERSION_RESET;
  logic [7:0]          rec_bytes [$];
  rec_flaw_e           flaw;
  int unsigned         flaw_head;
  int unsigned         head_no;
  int unsigned         flaw_pos;
  int unsigned         bytes_sent;
  int unsigned         records_sent;
  int unsigned         settings_used = 1;
  int unsigned         cycle_count;
  bit                  tx_calm;
  bit                  rx_calm;
  int unsigned         rx_hold;

  canonical_cbor_record_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .field_kind_o  (field_kind_o),
    .byte_index_o  (byte_index_o),
    .field_value_o (field_value_o),
    .status_o      (status_o),
    .record_end_o  (record_end_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  ccrd_stream_checker stream_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .field_kind_i  (field_kind_o),
    .byte_index_i  (byte_index_o),
    .field_value_i (field_value_o),
    .status_i      (status_o),
    .record_end_i  (record_end_o),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .mismatches_o  (mismatches),
    .compared_o    (compared),
    .pending_o     (pending)
  );

  always #5 clk_i = ~clk_i;

  // result side: after each transfer draw a random stall, with calm
  // stretches where ready stays high
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    int unsigned hold;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_hold     <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        hold = rx_calm ? 0 : $urandom_range(0, 10);
      end else begin
        hold = (rx_hold != 0) ? rx_hold - 1 : 0;
      end
      rx_hold     <= hold;
      out_ready_i <= (hold == 0);
    end
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one byte transfer; called at a rising edge and returns at the edge of
  // the transfer, so valid stays high when the next byte follows at once
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // stop sending and wait until every due result has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_version(input logic [7:0] ver);
    wait_idle();
    write_reg(VERSION_ADDR, {24'($urandom), ver});
    cfg_version = ver;
    settings_used++;
  endtask

  // unsigned argument spread over every head width when full is set (at most four bytes otherwise), boundaries included
  function automatic logic [63:0] pick_uint(input bit full);
    logic [63:0] v;
    case ($urandom_range(0, full ? 5 : 4))
      0: v = 64'($urandom_range(0, 23));
      1: v = 64'($urandom_range(24, 255));
      2: v = 64'($urandom_range(256, 65535));
      3: v = {32'd0, $urandom};
      4: begin
        case ($urandom_range(0, full ? 9 : 7))
          0: v = 64'd0;
          1: v = 64'd23;
          2: v = 64'd24;
          3: v = 64'hff;
          4: v = 64'h100;
          5: v = 64'hffff;
          6: v = 64'h1_0000;
          7: v = 64'hffff_ffff;
          8: v = 64'h1_0000_0000;
          default: v = '1;
        endcase
      end
      default: begin
        v = {$urandom, $urandom};
        if (v[63:32] == 32'd0) v[32] = 1'b1;
      end
    endcase
    return v;
  endfunction

  // append one head; the head picked for damage gets the record's flaw
  task automatic add_head(input logic [2:0] major, input logic [63:0] value);
    logic [2:0]  mj;
    logic [63:0] v;
    logic [4:0]  info;
    int unsigned code;
    int unsigned nbytes;
    bit          hit;
    mj  = major;
    v   = value;
    hit = (head_no == flaw_head);
    if (hit && flaw == REC_WIDE_VALUE) v = {$urandom_range(1, 32'hffff_ffff), $urandom};
    if (hit && flaw == REC_BAD_MAJOR) mj = major ^ 3'($urandom_range(1, 7));
    if (hit && flaw == REC_BAD_ARGUMENT) v = v ^ (64'd1 << $urandom_range(0, 5));
    // 0 inline, 1..4 for one, two, four and eight argument bytes
    code = (v < 64'(AI_INLINE_LIMIT)) ? 0 : (v <= 64'hff) ? 1 : (v <= 64'hffff) ? 2 :
           (v <= 64'hffff_ffff) ? 3 : 4;
    if (hit && flaw == REC_NONMINIMAL && code < 4) code = $urandom_range(code + 1, 4);
    info   = (code == 0) ? v[4:0] : AI_INLINE_LIMIT + 5'(code - 1);
    nbytes = (code == 0) ? 0 : (1 << (code - 1));
    if (hit && flaw == REC_RESERVED_INFO) begin
      info   = 5'($urandom_range(AI_ARG_U64 + 1, 31));
      nbytes = 0;
    end
    rec_bytes.push_back({mj, info});
    for (int i = nbytes; i > 0; i--) rec_bytes.push_back(8'(v >> (8 * (i - 1))));
    if (hit) flaw_pos = rec_bytes.size() - 1;
    head_no++;
  endtask

  // one random record: the full layout with random content, then damaged
  // and cut as its flaw asks
  task automatic build_record();
    int unsigned r;
    int unsigned keep;
    rec_bytes.delete();
    head_no  = 0;
    flaw_pos = 0;
    r        = $urandom_range(0, 15);
    flaw     = (r >= 6 && r <= 13) ? rec_flaw_e'(r - 5) : REC_CLEAN;
    // heads 8 and 10 carry capability and lifetime
    if (flaw == REC_WIDE_VALUE) flaw_head = $urandom_range(0, 1) ? 8 : 10;
    else flaw_head = $urandom_range(0, 12);

    add_head(MAJOR_MAP, MAP_ENTRIES);
    add_head(MAJOR_UINT, 64'd0);
    add_head(MAJOR_UINT, {56'd0, cfg_version});
    add_head(MAJOR_UINT, 64'd1);
    add_head(MAJOR_BSTR, 64'(ID_BYTES));
    repeat (ID_BYTES) rec_bytes.push_back(8'($urandom));
    add_head(MAJOR_UINT, 64'd2);
    add_head(MAJOR_BSTR, 64'(ID_BYTES));
    repeat (ID_BYTES) rec_bytes.push_back(8'($urandom));
    add_head(MAJOR_UINT, 64'd3);
    add_head(MAJOR_UINT, pick_uint(1'b0));
    add_head(MAJOR_UINT, 64'd4);
    add_head(MAJOR_UINT, pick_uint(1'b0));
    add_head(MAJOR_UINT, 64'd5);
    add_head(MAJOR_UINT, pick_uint(1'b1));

    case (flaw)
      REC_CLEAN: keep = rec_bytes.size();
      REC_TRAILING: begin
        repeat ($urandom_range(1, 3)) rec_bytes.push_back(8'($urandom));
        keep = rec_bytes.size();
      end
      REC_CUT_SHORT: keep = $urandom_range(1, rec_bytes.size() - 1);
      REC_NOISE: begin
        rec_bytes.delete();
        repeat ($urandom_range(1, 12)) rec_bytes.push_back(8'($urandom));
        keep = rec_bytes.size();
      end
      // damaged head: up to six bytes after it are kept, or none
      default: begin
        keep = flaw_pos + 1 + $urandom_range(0, 6);
        if (keep > rec_bytes.size()) keep = rec_bytes.size();
      end
    endcase
    while (rec_bytes.size() > keep) void'(rec_bytes.pop_back());
  endtask

  task automatic run_records(input int unsigned n_bytes);
    int unsigned target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      build_record();
      for (int i = 0; i < rec_bytes.size(); i++)
        send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
      records_sent++;
      // now and then let the block run dry between records
      if ($urandom_range(0, 9) == 0) wait_idle();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hand-made runs under the reset version
    send_byte(8'hbc, 1'b1);  // reserved additional info on the map head
    send_byte(8'hbf, 1'b1);  // indefinite length map
    send_byte(8'h00, 1'b1);  // wrong major type for the map
    send_byte(8'ha6, 1'b1);  // good map head, then the payload ends
    send_byte(8'hb8, 1'b0);  // map count in one extra byte, not minimal
    send_byte(8'h06, 1'b1);
    send_byte(8'ha7, 1'b0);  // seven entries, rest discarded
    send_byte(8'hff, 1'b1);
    send_byte(8'ha6, 1'b0);  // wrong version
    send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b1);
    send_byte(8'ha6, 1'b0);  // version comes out, then ends early
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b1);
    send_byte(8'ha6, 1'b0);  // first key out of order
    send_byte(8'h01, 1'b1);
    send_byte(8'ha6, 1'b0);  // device id of seventeen bytes
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h51, 1'b1);
    records_sent += 10;

    run_records(PHASE_BYTES);
    set_version(8'h00);
    run_records(PHASE_BYTES);
    set_version(8'hff);
    run_records(PHASE_BYTES);
    // a write to an unmapped index must leave the version alone
    wait_idle();
    write_reg(SPARE_ADDR, $urandom);
    run_records(PHASE_BYTES);
    set_version(8'($urandom));
    run_records(PHASE_BYTES);

    wait_idle();
    $display("sent %0d records in %0d byte transfers under %0d version settings",
             records_sent, bytes_sent, settings_used);
    $display("compared %0d results, %0d mismatches", compared, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/ccrd_pkg.sv
rtl/core/canonical_cbor_record_decoder.sv
test/ccrd_stream_checker.sv
test/canonical_cbor_record_decoder_test.sv
